// ===== rtl/core/stt_pkg.sv =====
// Shared token kinds, scanner mode codes and character classification for the tokenizer.
package stt_pkg;

    // token kinds
    localparam logic [5:0] K_EOH      = 6'd0;
    localparam logic [5:0] K_LITERAL  = 6'd1;
    localparam logic [5:0] K_NUMBER   = 6'd2;
    localparam logic [5:0] K_STRING   = 6'd3;
    localparam logic [5:0] K_CHAR     = 6'd4;
    localparam logic [5:0] K_FLOAT    = 6'd5;
    localparam logic [5:0] K_KEYWORD0 = 6'd39;

    // error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN = 2'd1;
    localparam logic [1:0] ERR_CHAR    = 2'd2;
    localparam logic [1:0] ERR_STRING  = 2'd3;

    // scanner modes
    localparam logic [2:0] MODE_IDLE      = 3'd0;
    localparam logic [2:0] MODE_NUM       = 3'd1;
    localparam logic [2:0] MODE_IDENT     = 3'd2;
    localparam logic [2:0] MODE_OP        = 3'd3;
    localparam logic [2:0] MODE_STR       = 3'd4;
    localparam logic [2:0] MODE_CHR_BODY  = 3'd5;
    localparam logic [2:0] MODE_CHR_CLOSE = 3'd6;
    localparam logic [2:0] MODE_COMMENT   = 3'd7;

    localparam int TOKENS_PER_BYTE = 3;
    localparam int QUEUE_DEPTH     = 4;
    localparam int LEN_W           = 16;
    localparam int IND_W           = 8;

    localparam logic [23:0] KW_PACK [12] = '{
        24'h646566, 24'h726574, 24'h666F72, 24'h616F70, 24'h006966, 24'h006566,
        24'h006E66, 24'h6E6577, 24'h6F7574, 24'h00676F, 24'h6D6F64, 24'h757365
    };
    localparam logic [1:0] KW_LEN [12] = '{
        2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd2, 2'd3, 2'd3, 2'd2, 2'd3, 2'd3
    };

    typedef struct packed {
        logic       push;
        logic [1:0] count;
    } t_push;

    function automatic logic is_numeral(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               (c == 8'h5F);
    endfunction

    function automatic logic is_pairing(input logic [7:0] c);
        return (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2A) || (c == 8'h2F) ||
               (c == 8'h25) || (c == 8'h3C) || (c == 8'h3E) || (c == 8'h3D) ||
               (c == 8'h21);
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        unique case (c)
            8'h2E:   k = 6'd18;
            8'h2C:   k = 6'd19;
            8'h3A:   k = 6'd20;
            8'h3B:   k = 6'd22;
            8'h26:   k = 6'd27;
            8'h7C:   k = 6'd28;
            8'h7B:   k = 6'd32;
            8'h7D:   k = 6'd33;
            8'h28:   k = 6'd34;
            8'h29:   k = 6'd35;
            8'h5B:   k = 6'd36;
            8'h5D:   k = 6'd37;
            default: k = 6'd0;
        endcase
        return k;
    endfunction

    // returns {used, kind}; without a following byte the one-byte kind is given
    function automatic logic [6:0] op_kind(input logic [7:0] op, input logic [7:0] nxt,
                                           input logic has_nxt);
        logic [5:0] k;
        logic       used;
        used = 1'b1;
        k    = 6'd0;
        if (has_nxt && nxt == 8'h3D) begin
            unique case (op)
                8'h2B:   k = 6'd11;
                8'h2D:   k = 6'd12;
                8'h2A:   k = 6'd13;
                8'h2F:   k = 6'd14;
                8'h25:   k = 6'd15;
                8'h3C:   k = 6'd26;
                8'h3E:   k = 6'd25;
                8'h3D:   k = 6'd31;
                default: k = 6'd30;
            endcase
        end else if (has_nxt && op == 8'h2D && nxt == 8'h3E) begin
            k = 6'd16;
        end else if (has_nxt && op == 8'h3C && nxt == 8'h2D) begin
            k = 6'd17;
        end else begin
            used = 1'b0;
            unique case (op)
                8'h2B:   k = 6'd6;
                8'h2D:   k = 6'd7;
                8'h2A:   k = 6'd8;
                8'h2F:   k = 6'd9;
                8'h25:   k = 6'd10;
                8'h3C:   k = 6'd24;
                8'h3E:   k = 6'd23;
                8'h3D:   k = 6'd21;
                default: k = 6'd29;
            endcase
        end
        return {used, k};
    endfunction

    function automatic logic [5:0] ident_kind(input logic [23:0] prefix,
                                              input logic [15:0] len);
        logic [5:0] k;
        k = K_LITERAL;
        if (len[15:2] == 14'd0) begin
            for (int i = 11; i >= 0; i--) begin
                if (KW_LEN[i] == len[1:0] && KW_PACK[i] == prefix) begin
                    k = K_KEYWORD0 + 6'(i);
                end
            end
        end
        return k;
    endfunction

endpackage

// ===== rtl/core/stt_front.sv =====
// Front scanner: one byte per accepted cycle; updates scan state, forms up to three tokens.
module stt_front #(
    parameter int POSITION_WIDTH = 20,
    parameter int LINE_WIDTH     = 16,
    parameter int TW = 6 + POSITION_WIDTH + stt_pkg::LEN_W + LINE_WIDTH + stt_pkg::IND_W + 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic [7:0]                          i_text_byte,
    input  logic                                i_end_of_input,
    output stt_pkg::t_push                      o_push,
    output logic [stt_pkg::TOKENS_PER_BYTE*TW-1:0] o_tokens
);

    localparam int PW = POSITION_WIDTH;
    localparam int LW = LINE_WIDTH;

    logic [2:0]    r_mode,   n_mode;
    logic [7:0]    r_op,     n_op;
    logic [PW-1:0] r_start,  n_start;
    logic [15:0]   r_run,    n_run;
    logic [23:0]   r_prefix, n_prefix;
    logic          r_dot,    n_dot;
    logic [PW-1:0] r_pos,    n_pos;
    logic [LW-1:0] r_line,   n_line;
    logic [7:0]    r_ind,    n_ind;
    logic          r_als,    n_als;
    logic [LW-1:0] r_ltl,    n_ltl;
    logic          r_halt,   n_halt;

    logic [5:0]    e_kind  [3];
    logic [PW-1:0] e_start [3];
    logic [15:0]   e_len   [3];
    logic [LW-1:0] e_line  [3];
    logic [7:0]    e_ind   [3];
    logic [1:0]    e_err   [3];
    logic [1:0]    cnt;

    always_comb begin
        logic [7:0]    c;
        logic [PW-1:0] pos;
        logic          go_idle;
        logic [6:0]    opk;
        logic [5:0]    sk;
        n_mode = r_mode; n_op = r_op; n_start = r_start; n_run = r_run;
        n_prefix = r_prefix; n_dot = r_dot; n_pos = r_pos; n_line = r_line;
        n_ind = r_ind; n_als = r_als; n_ltl = r_ltl; n_halt = r_halt;
        for (int i = 0; i < 3; i++) begin
            e_kind[i] = '0; e_start[i] = '0; e_len[i] = '0;
            e_line[i] = '0; e_ind[i] = '0; e_err[i] = '0;
        end
        cnt     = 2'd0;
        c       = i_text_byte;
        pos     = r_pos;
        go_idle = 1'b0;
        opk     = stt_pkg::op_kind(r_op, c, 1'b1);
        sk      = stt_pkg::single_kind(c);
        if (i_accept && !r_halt) begin
            unique case (r_mode)
                stt_pkg::MODE_NUM: begin
                    if (stt_pkg::is_numeral(c) || c == 8'h2E) begin
                        if (c == 8'h2E) n_dot = 1'b1;
                        if (r_run != '1) n_run = r_run + 16'd1;
                    end else begin
                        e_kind[cnt] = r_dot ? stt_pkg::K_FLOAT : stt_pkg::K_NUMBER;
                        e_start[cnt] = r_start; e_len[cnt] = r_run;
                        e_line[cnt] = n_line; e_ind[cnt] = n_ind;
                        cnt = cnt + 2'd1; n_ltl = n_line;
                        n_mode = stt_pkg::MODE_IDLE; go_idle = 1'b1;
                    end
                end
                stt_pkg::MODE_IDENT: begin
                    if (stt_pkg::is_name_char(c)) begin
                        if (r_run < 16'd3) n_prefix = {r_prefix[15:0], c};
                        if (r_run != '1) n_run = r_run + 16'd1;
                    end else begin
                        e_kind[cnt] = stt_pkg::ident_kind(r_prefix, r_run);
                        e_start[cnt] = r_start; e_len[cnt] = r_run;
                        e_line[cnt] = n_line; e_ind[cnt] = n_ind;
                        cnt = cnt + 2'd1; n_ltl = n_line;
                        n_mode = stt_pkg::MODE_IDLE; go_idle = 1'b1;
                    end
                end
                stt_pkg::MODE_OP: begin
                    e_kind[cnt] = opk[5:0];
                    e_start[cnt] = r_start; e_len[cnt] = opk[6] ? 16'd2 : 16'd1;
                    e_line[cnt] = n_line; e_ind[cnt] = n_ind;
                    cnt = cnt + 2'd1; n_ltl = n_line;
                    n_mode = stt_pkg::MODE_IDLE;
                    go_idle = !opk[6];
                end
                stt_pkg::MODE_STR: begin
                    if (c == 8'h22) begin
                        e_kind[cnt] = stt_pkg::K_STRING;
                        e_start[cnt] = r_start; e_len[cnt] = r_run;
                        e_line[cnt] = n_line; e_ind[cnt] = n_ind;
                        cnt = cnt + 2'd1; n_ltl = n_line;
                        n_mode = stt_pkg::MODE_IDLE;
                    end else if (r_run != '1) begin
                        n_run = r_run + 16'd1;
                    end
                end
                stt_pkg::MODE_CHR_BODY: begin
                    n_start = pos;
                    n_mode  = stt_pkg::MODE_CHR_CLOSE;
                end
                stt_pkg::MODE_CHR_CLOSE: begin
                    e_start[cnt] = (c == 8'h27) ? r_start : pos;
                    e_kind[cnt] = (c == 8'h27) ? stt_pkg::K_CHAR : stt_pkg::K_EOH;
                    e_len[cnt] = (c == 8'h27) ? 16'd1 : 16'd0;
                    e_line[cnt] = n_line; e_ind[cnt] = n_ind;
                    e_err[cnt] = (c == 8'h27) ? stt_pkg::ERR_NONE : stt_pkg::ERR_CHAR;
                    cnt = cnt + 2'd1;
                    if (c == 8'h27) n_ltl = n_line;
                    else n_halt = 1'b1;
                    n_mode = stt_pkg::MODE_IDLE;
                end
                stt_pkg::MODE_COMMENT: begin
                    if (c == 8'h0A) begin
                        n_mode = stt_pkg::MODE_IDLE; go_idle = 1'b1;
                    end
                end
                stt_pkg::MODE_IDLE: begin
                    go_idle = 1'b1;
                end
            endcase

            if (go_idle) begin
                priority if (c == 8'h0A) begin
                    if (n_line != '1) n_line = n_line + 1'b1;
                    n_ind = 8'd0;
                    n_als = 1'b1;
                end else if (c == 8'h20 || c == 8'h09 || c == 8'h0D) begin
                    if (n_als && n_ind != 8'hFF) n_ind = n_ind + 8'd1;
                end else begin
                    n_als = 1'b0;
                    priority if (stt_pkg::is_numeral(c)) begin
                        n_mode = stt_pkg::MODE_NUM; n_start = pos;
                        n_run = 16'd1; n_dot = 1'b0;
                    end else if (stt_pkg::is_name_char(c)) begin
                        n_mode = stt_pkg::MODE_IDENT; n_start = pos;
                        n_run = 16'd1; n_prefix = {16'd0, c};
                    end else if (stt_pkg::is_pairing(c)) begin
                        n_mode = stt_pkg::MODE_OP; n_op = c; n_start = pos;
                    end else if (sk != 6'd0) begin
                        e_kind[cnt] = sk; e_start[cnt] = pos; e_len[cnt] = 16'd1;
                        e_line[cnt] = n_line; e_ind[cnt] = n_ind;
                        cnt = cnt + 2'd1; n_ltl = n_line;
                    end else if (c == 8'h23) begin
                        n_mode = stt_pkg::MODE_COMMENT;
                    end else if (c == 8'h27) begin
                        n_mode = stt_pkg::MODE_CHR_BODY;
                    end else if (c == 8'h22) begin
                        n_mode  = stt_pkg::MODE_STR;
                        n_start = (pos != '1) ? pos + 1'b1 : pos;
                        n_run   = 16'd0;
                    end else if (c != 8'h00) begin
                        e_kind[cnt] = stt_pkg::K_EOH; e_start[cnt] = pos;
                        e_len[cnt] = 16'd0; e_line[cnt] = n_line; e_ind[cnt] = n_ind;
                        e_err[cnt] = stt_pkg::ERR_UNKNOWN;
                        cnt = cnt + 2'd1;
                        n_halt = 1'b1; n_mode = stt_pkg::MODE_IDLE;
                    end else begin
                        n_als = 1'b0;
                    end
                end
            end

            if (r_pos != '1) n_pos = r_pos + 1'b1;

            if (!n_halt && i_end_of_input) begin
                unique case (n_mode)
                    stt_pkg::MODE_NUM, stt_pkg::MODE_IDENT, stt_pkg::MODE_OP: begin
                        unique case (n_mode)
                            stt_pkg::MODE_NUM:
                                e_kind[cnt] = n_dot ? stt_pkg::K_FLOAT : stt_pkg::K_NUMBER;
                            stt_pkg::MODE_IDENT:
                                e_kind[cnt] = stt_pkg::ident_kind(n_prefix, n_run);
                            default:
                                e_kind[cnt] = 6'(stt_pkg::op_kind(n_op, c, 1'b0));
                        endcase
                        e_start[cnt] = n_start;
                        e_len[cnt] = (n_mode == stt_pkg::MODE_OP) ? 16'd1 : n_run;
                        e_line[cnt] = n_line; e_ind[cnt] = n_ind;
                        cnt = cnt + 2'd1; n_ltl = n_line;
                    end
                    stt_pkg::MODE_STR, stt_pkg::MODE_CHR_BODY, stt_pkg::MODE_CHR_CLOSE: begin
                        e_kind[cnt] = stt_pkg::K_EOH; e_start[cnt] = pos;
                        e_len[cnt] = 16'd0; e_line[cnt] = n_line; e_ind[cnt] = n_ind;
                        e_err[cnt] = (n_mode == stt_pkg::MODE_STR) ? stt_pkg::ERR_STRING
                                                                   : stt_pkg::ERR_CHAR;
                        cnt = cnt + 2'd1;
                        n_halt = 1'b1; n_mode = stt_pkg::MODE_IDLE;
                    end
                    default: begin
                    end
                endcase
                if (!n_halt) begin
                    e_kind[cnt]  = stt_pkg::K_EOH;
                    e_start[cnt] = (pos != '1) ? pos + 1'b1 : pos;
                    e_len[cnt]   = 16'd0;
                    e_line[cnt]  = (n_ltl != '1) ? n_ltl + 1'b1 : n_ltl;
                    e_ind[cnt]   = 8'd0;
                    cnt = cnt + 2'd1;
                    // back to reset state for the next buffer
                    n_mode = stt_pkg::MODE_IDLE; n_op = 8'd0; n_start = '0; n_run = 16'd0;
                    n_prefix = 24'd0; n_dot = 1'b0; n_pos = '0; n_line = LW'(1);
                    n_ind = 8'd0; n_als = 1'b1; n_ltl = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= stt_pkg::MODE_IDLE; r_op <= 8'd0; r_start <= '0; r_run <= 16'd0;
            r_prefix <= 24'd0; r_dot <= 1'b0; r_pos <= '0; r_line <= LW'(1);
            r_ind <= 8'd0; r_als <= 1'b1; r_ltl <= '0; r_halt <= 1'b0;
        end else begin
            r_mode <= n_mode; r_op <= n_op; r_start <= n_start; r_run <= n_run;
            r_prefix <= n_prefix; r_dot <= n_dot; r_pos <= n_pos; r_line <= n_line;
            r_ind <= n_ind; r_als <= n_als; r_ltl <= n_ltl; r_halt <= n_halt;
        end
    end

    always_comb begin
        o_push.push  = (cnt != 2'd0);
        o_push.count = cnt;
        for (int i = 0; i < 3; i++) begin
            o_tokens[i*TW +: TW] = {e_kind[i], e_start[i], e_len[i], e_line[i],
                                    e_ind[i], e_err[i]};
        end
    end

endmodule

// ===== rtl/core/stt_back.sv =====
// Back end: queue of per-byte groups, drained one token per cycle into a free output register.
module stt_back #(
    parameter int TW = 68
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  stt_pkg::t_push                         i_push,
    input  logic [stt_pkg::TOKENS_PER_BYTE*TW-1:0] i_tokens,
    output logic                                   o_full,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [TW-1:0]                          o_token,
    output logic                                   o_last
);

    localparam int GW = stt_pkg::TOKENS_PER_BYTE * TW;

    logic [GW-1:0] r_grp [stt_pkg::QUEUE_DEPTH];
    logic [1:0]    r_gcnt [stt_pkg::QUEUE_DEPTH];
    logic [1:0]    r_wr, r_rd, r_idx;
    logic [2:0]    r_cnt;
    logic          r_ov;
    logic [TW-1:0] r_tok;
    logic          r_last;

    logic [GW-1:0] head;
    logic          load, pop, tail;

    assign head   = r_grp[r_rd];
    assign tail   = (r_idx == r_gcnt[r_rd] - 2'd1);
    assign load   = (r_cnt != 3'd0) && (!r_ov || i_ready);
    assign pop    = load && tail;
    assign o_full = (r_cnt == 3'(stt_pkg::QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_grp[r_wr]  <= i_tokens;
            r_gcnt[r_wr] <= i_push.count;
        end
        if (load) begin
            r_tok  <= head[r_idx*TW +: TW];
            r_last <= tail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_idx <= 2'd0;
            r_cnt <= 3'd0;
            r_ov  <= 1'b0;
        end else begin
            if (i_push.push) r_wr <= r_wr + 2'd1;
            if (pop) r_rd <= r_rd + 2'd1;
            if (load) r_idx <= tail ? 2'd0 : r_idx + 2'd1;
            r_cnt <= r_cnt + 3'(i_push.push) - 3'(pop);
            // hold the result until taken, refill when it leaves
            if (load) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end

    assign o_valid = r_ov;
    assign o_token = r_tok;
    assign o_last  = r_last;

endmodule

// ===== rtl/core/source_text_tokenizer.sv =====
// Tokenizer top level: a source byte in, a token out per cycle unless stalled.
// A byte is taken every cycle while the token queue has room; the scanner
// finishes each byte in that cycle and hands any tokens, up to three, to a
// four-entry queue as one group; the back end sends one token per cycle from
// an output register, so the first token of a byte passes the queue, then
// the output register. Bytes that close two or three tokens at once outpace
// the one-token-per-cycle output, and then the queue fills and o_in_ready
// drops. After an error every byte is swallowed with no tokens until reset.
module source_text_tokenizer #(
    parameter int POSITION_WIDTH = 20,
    parameter int LINE_WIDTH     = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [7:0]                i_text_byte,
    input  logic                      i_end_of_input,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [5:0]                o_token_kind,
    output logic [POSITION_WIDTH-1:0] o_token_start,
    output logic [15:0]               o_token_length,
    output logic [LINE_WIDTH-1:0]     o_line_number,
    output logic [7:0]                o_indent_column,
    output logic [1:0]                o_error_code,
    output logic                      o_last_of_run
);

    localparam int TW = 6 + POSITION_WIDTH + stt_pkg::LEN_W + LINE_WIDTH + stt_pkg::IND_W + 2;

    stt_pkg::t_push                         push;
    logic [stt_pkg::TOKENS_PER_BYTE*TW-1:0] tokens;
    logic                                   full;
    logic [TW-1:0]                          tok;

    assign o_in_ready = !full;

    stt_front #(
        .POSITION_WIDTH(POSITION_WIDTH),
        .LINE_WIDTH(LINE_WIDTH),
        .TW(TW)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_accept(i_in_valid && !full),
        .i_text_byte(i_text_byte),
        .i_end_of_input(i_end_of_input),
        .o_push(push),
        .o_tokens(tokens)
    );

    stt_back #(
        .TW(TW)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(push),
        .i_tokens(tokens),
        .o_full(full),
        .o_valid(o_out_valid),
        .i_ready(i_out_ready),
        .o_token(tok),
        .o_last(o_last_of_run)
    );

    assign {o_token_kind, o_token_start, o_token_length, o_line_number,
            o_indent_column, o_error_code} = tok;

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_code != stt_pkg::ERR_NONE |-> o_last_of_run)
        else $error("error token not last of its byte");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_code != stt_pkg::ERR_NONE
        |-> o_token_kind == stt_pkg::K_EOH && o_token_length == 16'd0)
        else $error("error token malformed");

    a_eoh_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_kind == stt_pkg::K_EOH && o_error_code == stt_pkg::ERR_NONE
        |-> o_last_of_run && o_indent_column == 8'd0)
        else $error("end marker not last or indented");

endmodule
